[src/rgbnv12_pkg.sv]
// ----------------------------------------------------------------------------
// rgbnv12_pkg
// shared types and constants of the rgb to nv12 converter
// ----------------------------------------------------------------------------
package rgbnv12_pkg;

  typedef logic [16:0] acc_t;

  // configuration register indexes
  localparam logic REG_WIDTH_PAIRS = 1'b0;
  localparam logic REG_HEIGHT      = 1'b1;

  localparam logic [11:0] WIDTH_PAIRS_RST = 12'd960;
  localparam logic [12:0] HEIGHT_RST      = 13'd1080;

  // luma coefficients
  localparam acc_t Y_R   = 17'd66;
  localparam acc_t Y_G   = 17'd129;
  localparam acc_t Y_B   = 17'd25;
  localparam acc_t ROUND = 17'd128;
  localparam logic [7:0] LUMA_OFS = 8'd16;

  // chroma coefficients, signs applied in the datapath
  localparam acc_t CB_R = 17'd38;
  localparam acc_t CB_G = 17'd74;
  localparam acc_t CB_B = 17'd112;
  localparam acc_t CR_R = 17'd112;
  localparam acc_t CR_G = 17'd94;
  localparam acc_t CR_B = 17'd18;
  // rounding plus the 128 offset, which also keeps the sum positive
  localparam acc_t CHROMA_BIAS = 17'd32896;

  typedef struct packed {
    logic [8:0] r;
    logic [8:0] g;
    logic [8:0] b;
  } pair_sum_t;

  typedef struct packed {
    logic odd_col;
    logic odd_row;
    logic last_row;
  } pix_pos_t;

endpackage

[src/rgbnv12_csc.sv]
// ----------------------------------------------------------------------------
// rgbnv12_csc
// bt.601 luma per pixel and chroma of a completed 2x2 block or of a lone last row
// ----------------------------------------------------------------------------
module rgbnv12_csc (
  input  logic [7:0]                red_i,
  input  logic [7:0]                green_i,
  input  logic [7:0]                blue_i,
  input  rgbnv12_pkg::pair_sum_t    cur_sum_i,
  input  rgbnv12_pkg::pair_sum_t    line_sum_i,
  input  rgbnv12_pkg::pix_pos_t     pos_i,
  output logic [7:0]                luma_o,
  output logic                      chroma_valid_o,
  output logic [7:0]                cb_sample_o,
  output logic [7:0]                cr_sample_o
);

  rgbnv12_pkg::acc_t luma_sum;
  rgbnv12_pkg::acc_t cb_sum;
  rgbnv12_pkg::acc_t cr_sum;
  logic [9:0]        tot_r, tot_g, tot_b;
  rgbnv12_pkg::acc_t avg_r, avg_g, avg_b;
  logic              emit;

  assign luma_sum = rgbnv12_pkg::Y_R * 17'(red_i) + rgbnv12_pkg::Y_G * 17'(green_i)
                  + rgbnv12_pkg::Y_B * 17'(blue_i) + rgbnv12_pkg::ROUND;
  assign luma_o   = luma_sum[15:8] + rgbnv12_pkg::LUMA_OFS;

  // odd row adds the stored even row, a lone last even row counts twice
  always_comb begin
    if (pos_i.odd_row) begin
      tot_r = 10'(cur_sum_i.r) + 10'(line_sum_i.r);
      tot_g = 10'(cur_sum_i.g) + 10'(line_sum_i.g);
      tot_b = 10'(cur_sum_i.b) + 10'(line_sum_i.b);
    end else begin
      tot_r = {cur_sum_i.r, 1'b0};
      tot_g = {cur_sum_i.g, 1'b0};
      tot_b = {cur_sum_i.b, 1'b0};
    end
  end

  assign avg_r = 17'(tot_r[9:2]);
  assign avg_g = 17'(tot_g[9:2]);
  assign avg_b = 17'(tot_b[9:2]);

  assign cb_sum = rgbnv12_pkg::CB_B * avg_b + rgbnv12_pkg::CHROMA_BIAS
                - rgbnv12_pkg::CB_R * avg_r - rgbnv12_pkg::CB_G * avg_g;
  assign cr_sum = rgbnv12_pkg::CR_R * avg_r + rgbnv12_pkg::CHROMA_BIAS
                - rgbnv12_pkg::CR_G * avg_g - rgbnv12_pkg::CR_B * avg_b;

  assign emit           = pos_i.odd_col && (pos_i.odd_row || pos_i.last_row);
  assign chroma_valid_o = emit;
  assign cb_sample_o    = emit ? cb_sum[15:8] : 8'd0;
  assign cr_sample_o    = emit ? cr_sum[15:8] : 8'd0;

endmodule

[src/rgb_to_nv12_converter.sv]
// ----------------------------------------------------------------------------
// rgb_to_nv12_converter
// streaming bt.601 rgb to 4:2:0 ycbcr converter with one line of pair sums
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless stalled and returns one transaction per pixel
// through an input stage that also reads or writes the line memory, and an output
// register. The line memory holds MAX_WIDTH/2 entries of 27 bits, one per pixel
// pair of the even row, written on even rows and read on odd rows through one
// port; it needs no clearing after reset. Chroma is reported on the odd column of
// each odd row, or of a final even row that is paired with itself. Configuration
// must be written only while no transaction is in flight, which is not enforced.
module rgb_to_nv12_converter #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  luma_o,
  output logic        chroma_valid_o,
  output logic [7:0]  cb_sample_o,
  output logic [7:0]  cr_sample_o,
  output logic        end_of_frame_o
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam logic [13:0] LINE_DEPTH_W = 14'(LINE_DEPTH);
  localparam logic [13:0] MAX_HEIGHT_W = 14'(MAX_HEIGHT);

  logic [11:0] width_pairs_q;
  logic [12:0] height_q;

  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [23:0]   held_q;

  logic [13:0] pairs_eff, height_eff, last_col_pos, last_row_pos;
  logic        last_col, last_row, in_acc, out_free, s1_to_out;
  logic [AW-1:0] line_addr;
  rgbnv12_pkg::pair_sum_t cur_sum;
  rgbnv12_pkg::pix_pos_t  cur_pos;

  logic                   s1_valid_q;
  logic [7:0]             s1_r_q, s1_g_q, s1_b_q;
  rgbnv12_pkg::pair_sum_t s1_sum_q;
  rgbnv12_pkg::pix_pos_t  s1_pos_q;
  logic                   s1_eof_q;
  rgbnv12_pkg::pair_sum_t line_rd_q;
  rgbnv12_pkg::pair_sum_t line_mem [LINE_DEPTH];

  logic       out_valid_q;
  logic [7:0] luma_q, cb_q, cr_q;
  logic       cvalid_q, eof_q;
  logic [7:0] luma_c, cb_c, cr_c;
  logic       cvalid_c;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_pairs_q <= rgbnv12_pkg::WIDTH_PAIRS_RST;
      height_q      <= rgbnv12_pkg::HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rgbnv12_pkg::REG_WIDTH_PAIRS: width_pairs_q <= cfg_data_i[11:0];
        rgbnv12_pkg::REG_HEIGHT:      height_q      <= cfg_data_i;
        default:                      height_q      <= height_q;
      endcase
    end
  end

  always_comb begin
    pairs_eff = 14'(width_pairs_q);
    if (pairs_eff == 14'd0) pairs_eff = 14'd1;
    if (pairs_eff > LINE_DEPTH_W) pairs_eff = LINE_DEPTH_W;
    height_eff = 14'(height_q);
    if (height_eff == 14'd0) height_eff = 14'd1;
    if (height_eff > MAX_HEIGHT_W) height_eff = MAX_HEIGHT_W;
  end

  assign last_col_pos = {pairs_eff[12:0], 1'b0} - 14'd1;
  assign last_row_pos = height_eff - 14'd1;
  assign last_col     = 14'(col_q) >= last_col_pos;
  assign last_row     = 14'(row_q) >= last_row_pos;

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_to_out  = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign line_addr = AW'(col_q >> 1);
  assign cur_sum.r = 9'(red_i) + 9'(held_q[23:16]);
  assign cur_sum.g = 9'(green_i) + 9'(held_q[15:8]);
  assign cur_sum.b = 9'(blue_i) + 9'(held_q[7:0]);
  assign cur_pos.odd_col  = col_q[0];
  assign cur_pos.odd_row  = row_q[0];
  assign cur_pos.last_row = last_row;

  // position counters and held even pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      held_q <= '0;
    end else if (in_acc) begin
      if (!col_q[0]) begin
        held_q <= {red_i, green_i, blue_i};
      end
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // line memory, even rows write pair sums, odd rows read them
  always_ff @(posedge clk_i) begin
    if (in_acc && col_q[0]) begin
      if (!row_q[0]) begin
        line_mem[line_addr] <= cur_sum;
      end else begin
        line_rd_q <= line_mem[line_addr];
      end
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_to_out) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_r_q   <= red_i;
      s1_g_q   <= green_i;
      s1_b_q   <= blue_i;
      s1_sum_q <= cur_sum;
      s1_pos_q <= cur_pos;
      s1_eof_q <= last_col && last_row;
    end
  end

  rgbnv12_csc u_csc (
    .red_i          (s1_r_q),
    .green_i        (s1_g_q),
    .blue_i         (s1_b_q),
    .cur_sum_i      (s1_sum_q),
    .line_sum_i     (line_rd_q),
    .pos_i          (s1_pos_q),
    .luma_o         (luma_c),
    .chroma_valid_o (cvalid_c),
    .cb_sample_o    (cb_c),
    .cr_sample_o    (cr_c)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_to_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_to_out) begin
      luma_q   <= luma_c;
      cvalid_q <= cvalid_c;
      cb_q     <= cb_c;
      cr_q     <= cr_c;
      eof_q    <= s1_eof_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign luma_o         = luma_q;
  assign chroma_valid_o = cvalid_q;
  assign cb_sample_o    = cb_q;
  assign cr_sample_o    = cr_q;
  assign end_of_frame_o = eof_q;

  // checks
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with an empty input stage");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_col && last_row) |=> (col_q == '0) && (row_q == '0))
    else $error("position not cleared after the last pixel of a frame");

  a_no_chroma_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !chroma_valid_o) |-> (cb_sample_o == 8'd0) && (cr_sample_o == 8'd0))
    else $error("chroma samples nonzero without chroma");

  a_luma_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (luma_o >= 8'd16) && (luma_o <= 8'd235))
    else $error("luma out of studio range");

endmodule
